>>> design/skf_pkg.sv
package skf_pkg;

   // default geometry
   localparam int SAMPLE_WIDTH_DEFAULT  = 32;
   localparam int VARIANCE_FRAC_DEFAULT = 32;

   // fixed field widths on the channels
   localparam int MEAS_WIDTH     = 32;
   localparam int EST_WIDTH      = 32;
   localparam int GAIN_FRAC      = 32;
   localparam int GAIN_WIDTH     = GAIN_FRAC + 1;
   localparam int CSR_DATA_WIDTH = 48;
   localparam int CSR_INDEX_WIDTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEASUREMENT_NOISE = 2'd1;

   // item kinds
   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // reset value of the process noise register
   localparam longint unsigned PROCESS_NOISE_RESET = 64'd42950;

   // gain of exactly one
   localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC{1'b0}}};

endpackage

>>> design/skf_ifs.sv
// measurement / restart word channel
interface skf_req_if import skf_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic signed [MEAS_WIDTH-1:0]  measurement;

   modport source (output valid, kind, measurement, input ready);
   modport sink   (input valid, kind, measurement, output ready);
endinterface

// result word channel
interface skf_rsp_if import skf_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [EST_WIDTH-1:0]  estimate;
   logic [GAIN_WIDTH-1:0]        gain;

   modport source (output valid, estimate, gain, input ready);
   modport sink   (input valid, estimate, gain, output ready);
endinterface

// register write channel
interface skf_csr_if import skf_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [CSR_INDEX_WIDTH-1:0]  index;
   logic [CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/scalar_kalman_filter.sv
// scalar kalman filter, random-walk model, estimate Q16.16, variance Q16.F
//
// req_chan takes one word per item: kind selects a measurement update or a
// restart that sets the variance back to one. rsp_chan returns one word per
// item: the new estimate and the gain used (zero on restart).
// csr_chan writes process noise (index 0) or measurement noise (index 1);
// write only while the filter is idle. csr_chan is always ready.
//
// a measurement runs through a 33-step restoring divider for the gain; the
// two products with the gain are built bit by bit from the quotient bits as
// they come out, so the divider loop sets the time. a measurement passes
// through prep, sign, div (skipped on a zero denominator), fin1, fin2 and
// out before its result is loaded into the output register; a restart goes
// straight to out. a new word is taken only once the last result is loaded.
//
// reset clears the estimate to zero, the variance and measurement noise to
// one and process noise to its default; no result is pending after reset.
// the result sits in an output register; if rsp_chan stalls, a finished
// item waits there and the filter holds its next result until it drains.
module scalar_kalman_filter import skf_pkg::*; #(
   parameter int SAMPLE_WIDTH       = SAMPLE_WIDTH_DEFAULT,
   parameter int VARIANCE_FRAC_BITS = VARIANCE_FRAC_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   skf_req_if.sink    req_chan,
   skf_rsp_if.source  rsp_chan,
   skf_csr_if.sink    csr_chan
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int VW = VARIANCE_FRAC_BITS + 16;
   localparam int EW = (SW > MEAS_WIDTH) ? SW : MEAS_WIDTH;
   localparam int CW = (VW > CSR_DATA_WIDTH) ? VW : CSR_DATA_WIDTH;
   localparam int MW = SW + GAIN_FRAC + 1;
   localparam int PW = VW + GAIN_FRAC;
   localparam int DIV_STEPS = GAIN_FRAC + 1;
   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS);
   localparam logic [VW-1:0] VAR_ONE = {{(VW-1){1'b0}}, 1'b1} << VARIANCE_FRAC_BITS;
   localparam logic [VW-1:0] VAR_MAX = {VW{1'b1}};
   localparam logic [MW-1:0] HALF_M  = MW'(1) << (GAIN_FRAC - 1);
   localparam logic [PW-1:0] HALF_P  = PW'(1) << (GAIN_FRAC - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_SIGN = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN1 = 3'd4;
   localparam logic [2:0] ST_FIN2 = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  kind_ff, kind_in;
   logic [SW-1:0]         meas_ff, meas_in;
   logic [SW-1:0]         estimate_ff, estimate_in;
   logic [VW-1:0]         variance_ff, variance_in;
   logic [VW-1:0]         pnoise_ff, pnoise_in;
   logic [VW-1:0]         mnoise_ff, mnoise_in;
   logic [VW:0]           sum_ff, sum_in;
   logic [SW:0]           diff_ff, diff_in;
   logic [SW:0]           mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [VW:0]           rem_ff, rem_in;
   logic [GAIN_WIDTH-1:0] quo_ff, quo_in;
   logic                  qbit_ff, qbit_in;
   logic [MW-1:0]         accm_ff, accm_in;
   logic [PW-1:0]         accp_ff, accp_in;
   logic [SW:0]           step_ff, step_in;
   logic [VW-1:0]         vprod_ff, vprod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EST_WIDTH-1:0]  rsp_est_ff, rsp_est_in;
   logic [GAIN_WIDTH-1:0] rsp_gain_ff, rsp_gain_in;

   logic                  req_take;
   logic                  out_load;
   logic [EW-1:0]         meas_ext;
   logic [EW-1:0]         est_ext;
   logic [CW-1:0]         csr_ext;
   logic [VW+1:0]         trial;
   logic                  trial_ge;
   logic [PW-1:0]         vwide;
   logic [SW:0]           est_base;
   logic [VW:0]           vsum;

   // channel handshakes
   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign req_take        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready  = 1'b1;
   assign out_load        = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.estimate = rsp_est_ff;
   assign rsp_chan.gain     = rsp_gain_ff;

   // field extension and truncation
   assign meas_ext = EW'($unsigned(req_chan.measurement));
   assign est_ext  = EW'($signed(estimate_ff));
   assign csr_ext  = CW'(csr_chan.data);

   // one restoring divider step
   assign trial    = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign trial_ge = trial >= {1'b0, sum_ff};

   // rounding and update terms
   assign vwide    = {variance_ff, {GAIN_FRAC{1'b0}}} | HALF_P;
   assign est_base = {estimate_ff[SW-1], estimate_ff};
   assign vsum     = {1'b0, vprod_ff} + {1'b0, pnoise_ff};

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      meas_in      = meas_ff;
      estimate_in  = estimate_ff;
      variance_in  = variance_ff;
      pnoise_in    = pnoise_ff;
      mnoise_in    = mnoise_ff;
      sum_in       = sum_ff;
      diff_in      = diff_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      qbit_in      = qbit_ff;
      accm_in      = accm_ff;
      accp_in      = accp_ff;
      step_in      = step_ff;
      vprod_in     = vprod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_est_in   = rsp_est_ff;
      rsp_gain_in  = rsp_gain_ff;

      // register writes
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_PROCESS_NOISE:     pnoise_in = csr_ext[VW-1:0];
            CSR_MEASUREMENT_NOISE: mnoise_in = csr_ext[VW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in = req_chan.kind;
               meas_in = meas_ext[SW-1:0];
               quo_in  = '0;
               qbit_in = 1'b0;
               accm_in = '0;
               accp_in = '0;
               cnt_in  = '0;
               if (req_chan.kind == KIND_RESTART) begin
                  variance_in = VAR_ONE;
                  state_in    = ST_OUT;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         // denominator and innovation
         ST_PREP: begin
            sum_in   = {1'b0, variance_ff} + {1'b0, mnoise_ff};
            diff_in  = {meas_ff[SW-1], meas_ff} - est_base;
            state_in = ST_SIGN;
         end
         // magnitude of the innovation, divider seed
         ST_SIGN: begin
            neg_in   = diff_ff[SW];
            mag_in   = diff_ff[SW] ? (SW+1)'(-diff_ff) : diff_ff;
            rem_in   = {1'b0, variance_ff};
            cnt_in   = '0;
            state_in = (sum_ff == '0) ? ST_FIN1 : ST_DIV;
         end
         // divide, and fold last cycle's quotient bit into both products
         ST_DIV: begin
            accm_in = {accm_ff[MW-2:0], 1'b0} + (qbit_ff ? MW'(mag_ff) : '0);
            accp_in = {accp_ff[PW-2:0], 1'b0} + (qbit_ff ? PW'(variance_ff) : '0);
            if (cnt_ff != CNT_LAST) begin
               rem_in  = trial_ge ? (VW+1)'(trial - {1'b0, sum_ff}) : (VW+1)'(trial);
               quo_in  = {quo_ff[GAIN_WIDTH-2:0], trial_ge};
               qbit_in = trial_ge;
               cnt_in  = CNT_W'(cnt_ff + 1'b1);
            end else begin
               state_in = ST_FIN1;
            end
         end
         // round both products to the gain's binary point
         ST_FIN1: begin
            step_in  = (SW+1)'((accm_ff + HALF_M) >> GAIN_FRAC);
            vprod_in = VW'((vwide - accp_ff) >> GAIN_FRAC);
            state_in = ST_FIN2;
         end
         // estimate moves by the step, variance gets Q with saturation
         ST_FIN2: begin
            estimate_in = neg_ff ? SW'(est_base - step_ff) : SW'(est_base + step_ff);
            variance_in = vsum[VW] ? VAR_MAX : vsum[VW-1:0];
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_est_in   = est_ext[EST_WIDTH-1:0];
               rsp_gain_in  = quo_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         estimate_ff  <= '0;
         variance_ff  <= VAR_ONE;
         pnoise_ff    <= VW'(PROCESS_NOISE_RESET);
         mnoise_ff    <= VAR_ONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         estimate_ff  <= estimate_in;
         variance_ff  <= variance_in;
         pnoise_ff    <= pnoise_in;
         mnoise_ff    <= mnoise_in;
      end
      cnt_ff      <= cnt_in;
      kind_ff     <= kind_in;
      meas_ff     <= meas_in;
      sum_ff      <= sum_in;
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      qbit_ff     <= qbit_in;
      accm_ff     <= accm_in;
      accp_ff     <= accp_in;
      step_ff     <= step_in;
      vprod_ff    <= vprod_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   // divider remainder stays below the denominator
   a_rem_below_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff != '0) |-> rem_ff < sum_ff)
      else $error("divider remainder not below denominator");

   // restart puts the variance back to one
   a_restart_variance: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.kind == KIND_RESTART) |=> variance_ff == VAR_ONE)
      else $error("restart did not reset the variance");

   // restart result carries zero gain
   a_restart_gain: assert property (@(posedge clock) disable iff (reset)
      (out_load && kind_ff == KIND_RESTART) |=> rsp_chan.gain == '0)
      else $error("restart result with nonzero gain");

   // gain never above one
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.gain <= GAIN_ONE)
      else $error("gain above one");

endmodule

>>> dv/scalar_kalman_filter_tb.sv
`timescale 1ns / 1ps

module scalar_kalman_filter_tb import skf_pkg::*; ();

   localparam int VAR_W        = VARIANCE_FRAC_DEFAULT + 16;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int SETTLE_CYCLES = 48;
   localparam int PHASE_WORDS  = 180;
   localparam int PHASE_COUNT  = 8;

   localparam logic [VAR_W-1:0] VAR_ONE = VAR_W'(64'd1 << VARIANCE_FRAC_DEFAULT);
   localparam logic [VAR_W-1:0] VAR_MAX = '1;

   // register slots the filter does not decode
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic signed [MEAS_WIDTH-1:0] MEAS_MAX = 32'h7fff_ffff;
   localparam logic signed [MEAS_WIDTH-1:0] MEAS_MIN = 32'h8000_0000;

   typedef struct {
      logic signed [EST_WIDTH-1:0] estimate;
      logic [GAIN_WIDTH-1:0]       gain;
   } filter_word_type;

   // filter state tracker and result checker
   class kalman_scoreboard;
      logic [VAR_W-1:0]            noise_q;
      logic [VAR_W-1:0]            noise_r;
      logic [VAR_W-1:0]            variance;
      logic signed [EST_WIDTH-1:0] estimate;
      filter_word_type             awaited[$];
      int mismatches, measures, restarts, zero_gains, unit_gains, saturations;
      int writes, checked;

      function new();
         noise_q  = VAR_W'(PROCESS_NOISE_RESET);
         noise_r  = VAR_ONE;
         variance = VAR_ONE;
         estimate = '0;
         mismatches = 0; measures = 0; restarts = 0; zero_gains = 0;
         unit_gains = 0; saturations = 0; writes = 0; checked = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
         writes++;
         if (idx == CSR_PROCESS_NOISE)
            noise_q = value[VAR_W-1:0];
         else if (idx == CSR_MEASUREMENT_NOISE)
            noise_r = value[VAR_W-1:0];
      endfunction

      // advance the filter by one accepted word and queue the result it gives
      function void note_item(logic kind, logic signed [MEAS_WIDTH-1:0] meas);
         logic [VAR_W:0]        denom;
         logic [VAR_W+32:0]     numer;
         logic [GAIN_WIDTH-1:0] gain;
         logic [EST_WIDTH:0]    diff;
         logic [EST_WIDTH:0]    mag;
         logic [EST_WIDTH:0]    nudge;
         logic [127:0]          prod;
         logic [VAR_W+1:0]      next_var;
         filter_word_type       word;
         gain = '0;
         if (kind == KIND_RESTART) begin
            variance = VAR_ONE;
            restarts++;
         end else begin
            measures++;
            // gain = floor(P * 2^32 / (P + R)), zero when the sum is zero
            denom = {1'b0, variance} + {1'b0, noise_r};
            numer = {1'b0, variance, 32'd0};
            if (denom != 0)
               gain = GAIN_WIDTH'(numer / denom);
            // move toward the reading, magnitude rounded half away from zero
            diff  = {meas[MEAS_WIDTH-1], meas} - {estimate[EST_WIDTH-1], estimate};
            mag   = diff[EST_WIDTH] ? (~diff + 1'b1) : diff;
            prod  = 128'(mag) * 128'(gain) + (128'd1 << 31);
            nudge = prod[EST_WIDTH+32:32];
            if (diff[EST_WIDTH])
               estimate = estimate - nudge[EST_WIDTH-1:0];
            else
               estimate = estimate + nudge[EST_WIDTH-1:0];
            // shrink the variance, add Q, clip at the top
            prod     = 128'(variance) * 128'(GAIN_ONE - gain) + (128'd1 << 31);
            next_var = (VAR_W+2)'(prod[VAR_W+31:32]) + (VAR_W+2)'(noise_q);
            if (next_var > VAR_MAX) begin
               variance = VAR_MAX;
               saturations++;
            end else begin
               variance = next_var[VAR_W-1:0];
            end
            if (gain == 0) zero_gains++;
            if (gain == GAIN_ONE) unit_gains++;
         end
         word.estimate = estimate;
         word.gain     = gain;
         awaited.push_back(word);
      endfunction

      function void check_result(logic signed [EST_WIDTH-1:0] est, logic [GAIN_WIDTH-1:0] gain);
         filter_word_type want;
         if (awaited.size() == 0) begin
            $error("result word with nothing awaited: estimate %0d, gain %0d", est, gain);
            mismatches++;
         end else begin
            want = awaited.pop_front();
            checked++;
            if (est !== want.estimate) begin
               $error("estimate mismatch: expected %0d, actual %0d", want.estimate, est);
               mismatches++;
            end
            if (gain !== want.gain) begin
               $error("gain mismatch: expected %0d, actual %0d", want.gain, gain);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   ready_run = 0;
   logic ready_level = 1'b0;
   kalman_scoreboard board;

   skf_req_if req_if ();
   skf_rsp_if rsp_if ();
   skf_csr_if csr_if ();

   scalar_kalman_filter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** scalar_kalman_filter: FAILED **");
         $finish;
      end
   end

   // result side: check accepted words, stall in runs of random length
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_result(rsp_if.estimate, rsp_if.gain);
      if (ready_run == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            ready_level = 1'b1;
            ready_run   = $urandom_range(100, 400);
         end else begin
            ready_level = !ready_level;
            ready_run   = ready_level ? $urandom_range(1, 20) : $urandom_range(1, 24);
         end
      end else begin
         ready_run--;
      end
      rsp_if.ready <= ready_level;
   end

   // register write; valid stays up unless this is the last of a group
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value, input bit last);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      board.set_reg(idx, value);
      if (last) csr_if.valid <= 1'b0;
   endtask

   task automatic set_noise(input logic [VAR_W-1:0] q, input logic [VAR_W-1:0] r);
      write_reg(CSR_PROCESS_NOISE, q, 1'b0);
      write_reg(CSR_MEASUREMENT_NOISE, r, 1'b1);
   endtask

   // one input word; valid is left high for a following word
   task automatic send_word(input logic kind, input logic signed [MEAS_WIDTH-1:0] meas);
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind;
      req_if.measurement <= meas;
      do @(posedge clock); while (!req_if.ready);
      board.note_item(kind, meas);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // readings: full range, near the estimate, extremes, moderate spread
   function automatic logic signed [MEAS_WIDTH-1:0] pick_measurement();
      logic signed [MEAS_WIDTH-1:0] value;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: value = $urandom;
         4, 5, 6:    value = board.estimate + MEAS_WIDTH'($urandom_range(0, 8191))
                             - MEAS_WIDTH'(4096);
         7: begin
            case ($urandom_range(0, 3))
               0:       value = MEAS_MAX;
               1:       value = MEAS_MIN;
               2:       value = '0;
               default: value = '1;
            endcase
         end
         default: value = MEAS_WIDTH'($urandom_range(0, 2097152)) - MEAS_WIDTH'(1048576);
      endcase
      return value;
   endfunction

   // random words in bursts with short, no or long gaps
   task automatic run_words(input int total);
      int sent;
      int burst;
      int gap;
      logic kind;
      sent = 0;
      while (sent < total) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < total; i++) begin
            kind = ($urandom_range(0, 11) == 0) ? KIND_RESTART : KIND_MEASURE;
            send_word(kind, pick_measurement());
            sent++;
         end
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1, 2:    gap = $urandom_range(1, 8);
            default: gap = $urandom_range(20, 60);
         endcase
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      board = new();
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.kind        <= KIND_MEASURE;
      req_if.measurement <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= CSR_PROCESS_NOISE;
      csr_if.data        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: P = R = one gives a gain of one half, so odd steps tie
      send_word(KIND_MEASURE, 32'sd1);
      send_word(KIND_RESTART, MEAS_MAX);
      send_word(KIND_MEASURE, -32'sd4);
      send_word(KIND_MEASURE, MEAS_MAX);
      send_word(KIND_MEASURE, MEAS_MIN);
      send_word(KIND_MEASURE, '1);
      drain();

      // largest noise: variance runs into its ceiling
      set_noise(VAR_MAX, VAR_MAX);
      send_word(KIND_MEASURE, MEAS_MAX);
      send_word(KIND_MEASURE, MEAS_MIN);
      send_word(KIND_MEASURE, 32'sh1234_5678);
      send_word(KIND_MEASURE, MEAS_MIN);
      drain();

      // no noise: unit gain, then zero variance and a zero denominator
      set_noise('0, '0);
      send_word(KIND_MEASURE, 32'sd1000);
      send_word(KIND_MEASURE, -32'sd5000);
      send_word(KIND_MEASURE, MEAS_MAX);
      send_word(KIND_RESTART, '0);
      send_word(KIND_MEASURE, MEAS_MIN);
      drain();

      // huge R after zero variance: zero gain
      set_noise('0, VAR_MAX);
      send_word(KIND_MEASURE, MEAS_MAX);
      send_word(KIND_MEASURE, MEAS_MIN);
      drain();

      // writes to undecoded slots must leave the filter alone
      write_reg(CSR_SPARE_LO, 48'h5a5a_a5a5_5a5a, 1'b0);
      write_reg(CSR_SPARE_HI, 48'hffff_0000_ffff, 1'b1);
      send_word(KIND_MEASURE, 32'sd77);
      drain();

      // random phases across noise settings
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: set_noise(VAR_W'(PROCESS_NOISE_RESET), VAR_ONE);
            1: set_noise('0, VAR_MAX);
            2: set_noise(VAR_MAX, '0);
            3: set_noise(VAR_W'({$urandom, $urandom}), VAR_W'({$urandom, $urandom}));
            4: set_noise(VAR_W'($urandom_range(0, 16777215)), VAR_W'({$urandom, 4'h0}));
            5: set_noise('0, '0);
            6: set_noise(VAR_W'({$urandom, $urandom}), VAR_W'($urandom));
            default: set_noise(VAR_MAX, VAR_MAX);
         endcase
         run_words(PHASE_WORDS);
         drain();
      end

      if (board.awaited.size() != 0) begin
         $error("%0d result words never arrived", board.awaited.size());
         board.mismatches++;
      end
      $display("ran %0d measurements, %0d restarts, %0d register writes; %0d words checked",
               board.measures, board.restarts, board.writes, board.checked);
      $display("gain hit zero %0d times and one %0d times; variance clipped %0d times",
               board.zero_gains, board.unit_gains, board.saturations);
      if (board.mismatches == 0)
         $display("** scalar_kalman_filter: PASSED **");
      else
         $display("** scalar_kalman_filter: FAILED **");
      $finish;
   end

endmodule

>>> scalar_kalman_filter.f
design/skf_pkg.sv
design/skf_ifs.sv
design/scalar_kalman_filter.sv
dv/scalar_kalman_filter_tb.sv
